### rtl/ktaf_pkg.sv
// ----------------------------------------------------------------------------
// ktaf_pkg
// Types and constants for the tilt-angle Kalman filter.
// ----------------------------------------------------------------------------
package ktaf_pkg;

  localparam int FRAC = 24;

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_GYRO  = 2'd1,
    REG_R       = 2'd2,
    REG_DT      = 2'd3
  } reg_idx_t;

  localparam logic [23:0] RST_Q_ANGLE = 24'd5200937;
  localparam logic [23:0] RST_Q_GYRO  = 24'd251658;
  localparam logic [23:0] RST_R       = 24'd10066330;
  localparam logic [23:0] RST_DT      = 24'd33554;
  localparam logic signed [39:0] ONE_Q24 = 40'sd16777216;

  // a 64-bit signed value saturated to w bits with sign
  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                               input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (w - 1));
      if (v > hi) sat_w = hi;
      else if (v < lo) sat_w = lo;
      else sat_w = v;
    end
  endfunction

endpackage

### rtl/kalman_tilt_angle_filter.sv
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter
// Two-state Kalman filter (angle, gyro bias) with one shared multiplier
// and a restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// each request runs 11 products on the shared 32x32 multiplier
// (4 partial products per product) and, unless the gains are zero, two
// restoring divides; no new request is taken until the last result has
// been loaded into the output register; in_ready is low while busy
// reset: synchronous active low; config, estimate, covariance and control registers return to defaults
module kalman_tilt_angle_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_corrected_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import ktaf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_POST, S_DIV, S_DSTEP, S_DEND, S_OUT
  } state_t;

  state_t state_r;
  logic [23:0] qa_r, qg_r, rn_r, dt_r;
  logic signed [31:0] ang_r, bias_r, acc_r, gyro_r;
  logic signed [32:0] err_r;
  logic signed [39:0] c00_r, c01_r, c10_r, c11_r;
  logic signed [39:0] p00_r, p01_r, p10_r, p11_r, k0_r, k1_r;
  logic signed [41:0] e_r;
  logic [3:0] op_r;
  logic [1:0] pp_r;
  logic [63:0] ma_r, mb_r;
  logic neg_r;
  logic [95:0] macc_r;
  logic [63:0] num_r, quo_r;
  logic [64:0] rem_r;
  logic [6:0] dcnt_r;
  logic dsel_r;
  logic signed [31:0] oa_r, or_r;
  logic ov_r;

  logic signed [63:0] opa, opb, res, lim48;
  logic [31:0] pa, pb;
  logic [95:0] rnd;
  logic [63:0] mres;
  logic [64:0] rtrial;

  assign lim48 = 64'sd140737488355327;

  // operand select per product
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      4'd0: begin opa = 64'(gyro_r) - 64'(bias_r); opb = 64'(dt_r); end
      4'd1: begin opa = 64'(qa_r) - 64'(c01_r) - 64'(c10_r); opb = 64'(dt_r); end
      4'd2: begin opa = -64'(c11_r); opb = 64'(dt_r); end
      4'd3: begin opa = -64'(c11_r); opb = 64'(dt_r); end
      4'd4: begin opa = 64'(qg_r); opb = 64'(dt_r); end
      4'd5: begin opa = 64'(k0_r); opb = 64'(p00_r); end
      4'd6: begin opa = 64'(k0_r); opb = 64'(p01_r); end
      4'd7: begin opa = 64'(k1_r); opb = 64'(p00_r); end
      4'd8: begin opa = 64'(k1_r); opb = 64'(p01_r); end
      4'd9: begin opa = 64'(k0_r); opb = 64'(err_r); end
      4'd10: begin opa = 64'(k1_r); opb = 64'(err_r); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    pa = pp_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = pp_r[1] ? mb_r[63:32] : mb_r[31:0];
    rnd = macc_r + 96'(1 << (FRAC - 1));
    if (rnd[95:88] != '0) mres = '1;
    else mres = rnd[87:24];
    if (mres > 64'(lim48) + 64'(neg_r)) res = neg_r ? -lim48 - 64'sd1 : lim48;
    else res = neg_r ? -$signed(mres) : $signed(mres);
    rtrial = {rem_r[63:0], num_r[63]} - {1'b0, 64'(e_r)};
  end

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !ov_r && !in_valid;
  assign out_valid = ov_r;
  assign out_filtered_angle = oa_r;
  assign out_corrected_rate = or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qa_r <= RST_Q_ANGLE; qg_r <= RST_Q_GYRO; rn_r <= RST_R; dt_r <= RST_DT;
      ang_r <= '0; bias_r <= '0;
      c00_r <= ONE_Q24; c01_r <= '0; c10_r <= '0; c11_r <= ONE_Q24;
      ov_r <= 1'b0;
      op_r <= '0; pp_r <= '0; dcnt_r <= '0; dsel_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
              REG_Q_ANGLE: qa_r <= cfg_data;
              REG_Q_GYRO:  qg_r <= cfg_data;
              REG_R:       rn_r <= cfg_data;
              REG_DT:      dt_r <= cfg_data;
            endcase
          end
          if (in_valid) begin
            acc_r <= in_accel_angle;
            gyro_r <= in_gyro_rate;
            op_r <= 4'd0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ma_r <= opa[63] ? -opa : opa;
          mb_r <= opb[63] ? -opb : opb;
          neg_r <= opa[63] ^ opb[63];
          macc_r <= '0;
          pp_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          macc_r <= macc_r + ({32'd0, 64'(pa) * 64'(pb)}
                              << (32 * (32'(pp_r[0]) + 32'(pp_r[1]))));
          pp_r <= pp_r + 2'd1;
          if (pp_r == 2'd3) state_r <= S_POST;
        end
        S_POST: begin
          op_r <= op_r + 4'd1;
          state_r <= S_LOAD;
          case (op_r)
            4'd0: begin
              ang_r <= 32'(sat_w(64'(ang_r) + res, 32));
              err_r <= 33'(64'(acc_r) - sat_w(64'(ang_r) + res, 32));
            end
            4'd1: p00_r <= 40'(sat_w(64'(c00_r) + res, 40));
            4'd2: p01_r <= 40'(sat_w(64'(c01_r) + res, 40));
            4'd3: p10_r <= 40'(sat_w(64'(c10_r) + res, 40));
            4'd4: begin
              p11_r <= 40'(sat_w(64'(c11_r) + res, 40));
              e_r <= 42'(rn_r) + 42'(p00_r);
              dsel_r <= 1'b0;
              state_r <= S_DIV;
            end
            4'd5: c00_r <= 40'(sat_w(64'(p00_r) - res, 40));
            4'd6: c01_r <= 40'(sat_w(64'(p01_r) - res, 40));
            4'd7: c10_r <= 40'(sat_w(64'(p10_r) - res, 40));
            4'd8: c11_r <= 40'(sat_w(64'(p11_r) - res, 40));
            4'd9: ang_r <= 32'(sat_w(64'(ang_r) + res, 32));
            default: begin
              bias_r <= 32'(sat_w(64'(bias_r) + res, 32));
              state_r <= S_OUT;
            end
          endcase
        end
        S_DIV: begin
          if (e_r <= 0) begin
            k0_r <= '0; k1_r <= '0;
            state_r <= S_LOAD;
          end else begin
            num_r <= (dsel_r ? 64'(p10_r[39] ? -64'(p10_r) : 64'(p10_r))
                             : 64'(p00_r[39] ? -64'(p00_r) : 64'(p00_r))) << FRAC;
            rem_r <= '0;
            quo_r <= '0;
            dcnt_r <= '0;
            state_r <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          num_r <= num_r << 1;
          if (!rtrial[64]) begin
            rem_r <= rtrial;
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[63:0], num_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd63) state_r <= S_DEND;
        end
        S_DEND: begin
          // round: remainder*2 >= divisor rounds up
          logic [63:0] q;
          logic n;
          q = quo_r + 64'(({rem_r[63:0], 1'b0} >= {1'b0, 64'(e_r)}) ? 1 : 0);
          n = dsel_r ? p10_r[39] : p00_r[39];
          if (dsel_r) k1_r <= 40'(sat_w(n ? -$signed(q > 64'd549755813888 ?
                                 64'd549755813888 : q) : $signed(q > 64'd549755813887 ?
                                 64'd549755813887 : q), 40));
          else k0_r <= 40'(sat_w(n ? -$signed(q > 64'd549755813888 ?
                                 64'd549755813888 : q) : $signed(q > 64'd549755813887 ?
                                 64'd549755813887 : q), 40));
          if (dsel_r) state_r <= S_LOAD;
          else begin
            dsel_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_OUT: begin
          if (!ov_r) begin
            oa_r <= ang_r;
            or_r <= 32'(sat_w(64'(gyro_r) - 64'(bias_r), 32));
            ov_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ktaf_checker.sv
// ----------------------------------------------------------------------------
// ktaf_checker
// Port-level checks for the tilt-angle Kalman filter.
// ----------------------------------------------------------------------------
module ktaf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic [31:0] out_filtered_angle
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after request");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_angle))
    else $error("result dropped");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> in_ready) else $error("cfg while busy");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind kalman_tilt_angle_filter ktaf_checker u_ktaf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
  .out_filtered_angle(out_filtered_angle)
);
